// ===== rtl/core/pbd_pkg.sv =====
package pbd_pkg;

  localparam int unsigned ATOM_COUNT_DEF = 4096;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned LEN_W  = 31;
  localparam int unsigned DIST_W = 31;
  localparam int unsigned MAG_W  = 33;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 31'd65536;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } pos_t;

endpackage

// ===== rtl/core/pbd_pos_ram.sv =====
module pbd_pos_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  pbd_pkg::pos_t wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output pbd_pkg::pos_t rdata_a_o,
  output pbd_pkg::pos_t rdata_b_o
);
  import pbd_pkg::*;

  pos_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== rtl/core/pbd_axis.sv =====
module pbd_axis (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [pbd_pkg::MAG_W-1:0] mag_i,
  input  logic [pbd_pkg::LEN_W-1:0] len_i,
  output logic                      valid_o,
  output logic [pbd_pkg::SQ_W-1:0]  sq_o
);
  import pbd_pkg::*;

  logic             vld_q [MAG_W];
  logic [MAG_W-1:0] rem_q [MAG_W];
  logic [MAG_W-1:0] mag_q [MAG_W];

  logic             len_zero;
  assign len_zero = (len_i == '0);

  for (genvar k = 0; k < MAG_W; k++) begin : g_rem
    logic             vld_in;
    logic [MAG_W-1:0] rem_in;
    logic [MAG_W-1:0] mag_in;
    logic [MAG_W-1:0] tmp;
    logic [MAG_W-1:0] rem_d;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign mag_in = mag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign mag_in = mag_q[k-1];
    end

    always_comb begin
      tmp = {rem_in[MAG_W-2:0], mag_in[MAG_W-1]};
      if (!len_zero && tmp >= MAG_W'(len_i)) begin
        rem_d = tmp - MAG_W'(len_i);
      end else begin
        rem_d = tmp;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      mag_q[k] <= {mag_in[MAG_W-2:0], 1'b0};
    end
  end

  logic [MAG_W-1:0] rem_last;
  logic [MAG_W:0]   two_rem;
  logic [MAG_W-1:0] a_d, a_q;
  logic             a_vld_q, p_vld_q, s_vld_q;
  logic [33:0]      ph_q;
  logic [32:0]      pm_q;
  logic [31:0]      pl_q;
  logic [SQ_W-1:0]  sq_q;

  assign rem_last = rem_q[MAG_W-1];
  assign two_rem  = {rem_last, 1'b0};

  always_comb begin
    if (len_zero) begin
      a_d = rem_last;
    end else if (two_rem >= (MAG_W+1)'(len_i)) begin
      a_d = MAG_W'(len_i) - rem_last;
    end else begin
      a_d = rem_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_q[MAG_W-1];
      p_vld_q <= a_vld_q;
      s_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    ph_q <= a_q[32:16] * a_q[32:16];
    pm_q <= a_q[32:16] * a_q[15:0];
    pl_q <= a_q[15:0] * a_q[15:0];
    sq_q <= (SQ_W'(ph_q) << 32) + (SQ_W'(pm_q) << 17) + SQ_W'(pl_q);
  end

  assign valid_o = s_vld_q;
  assign sq_o    = sq_q;

endmodule

// ===== rtl/core/pbd_sqrt.sv =====
module pbd_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [pbd_pkg::SQ_W-1:0]   value_i,
  output logic                       valid_o,
  output logic [pbd_pkg::SQ_W/2-1:0] root_o
);
  import pbd_pkg::*;

  localparam int unsigned STAGES = SQ_W / 2;
  localparam int unsigned REM_W  = STAGES + 2;

  logic              vld_q  [STAGES];
  logic [SQ_W-1:0]   val_q  [STAGES];
  logic [REM_W-1:0]  rem_q  [STAGES];
  logic [STAGES-1:0] root_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_step
    logic              vld_in;
    logic [SQ_W-1:0]   val_in;
    logic [REM_W-1:0]  rem_in;
    logic [STAGES-1:0] root_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic [REM_W-1:0]  rem_d;
    logic [STAGES-1:0] root_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign val_in  = value_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign val_in  = val_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      cur   = {rem_in, val_in[SQ_W-1:SQ_W-2]};
      trial = (REM_W+2)'({root_in, 2'b01});
      if (cur >= trial) begin
        rem_d  = REM_W'(cur - trial);
        root_d = {root_in[STAGES-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(cur);
        root_d = {root_in[STAGES-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      val_q[k]  <= {val_in[SQ_W-3:0], 2'b00};
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign root_o  = root_q[STAGES-1];

endmodule

// ===== rtl/core/periodic_bond_distance.sv =====
// Channel  | Ports                                             | Dir | Handshake
// item in  | op_i first_index_i second_index_i pos_x/y/z_i     | in  | start & !busy
// result   | distance_o                                        | out | result_valid_o, 1 cycle
// config   | cfg_we_i cfg_idx_i cfg_data_i                     | in  | cfg_we_i
//
// One item enters per cycle; busy is never raised.
// A query gives its result after these registered steps: RAM read, difference,
// 33 remainder steps per axis, fold, square, sum and 32 square root steps.
// A store with first_index_i below ATOM_COUNT writes the position RAM at acceptance and gives no result.
// Reset clears the valid bits and sets each box length to 1.0; the RAM is not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
module periodic_bond_distance #(
  parameter int unsigned ATOM_COUNT = pbd_pkg::ATOM_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [pbd_pkg::IDX_W-1:0]     first_index_i,
  input  logic [pbd_pkg::IDX_W-1:0]     second_index_i,
  input  logic signed [pbd_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [pbd_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [pbd_pkg::POS_W-1:0] pos_z_i,
  input  logic                          cfg_we_i,
  input  logic [pbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pbd_pkg::LEN_W-1:0]     cfg_data_i,
  output logic                          result_valid_o,
  output logic [pbd_pkg::DIST_W-1:0]    distance_o
);
  import pbd_pkg::*;

  localparam int unsigned AW  = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;
  localparam int unsigned XW  = 17;

  logic [LEN_W-1:0] box_x_q, box_y_q, box_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= LEN_RESET;
      box_y_q <= LEN_RESET;
      box_z_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_X: box_x_q <= cfg_data_i;
        REG_BOX_Y: box_y_q <= cfg_data_i;
        REG_BOX_Z: box_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic          accept;
  logic [XW-1:0] ia_ext, ib_ext;
  logic          ia_ok, ib_ok;
  pos_t          wdata, rd_a, rd_b;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign ia_ext = XW'(first_index_i);
  assign ib_ext = XW'(second_index_i);
  assign ia_ok  = ia_ext < XW'(ATOM_COUNT);
  assign ib_ok  = ib_ext < XW'(ATOM_COUNT);
  assign wdata  = '{x: pos_x_i, y: pos_y_i, z: pos_z_i};

  pbd_pos_ram #(
    .DEPTH (ATOM_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (accept && op_i == OP_STORE && ia_ok),
    .waddr_i   (ia_ext[AW-1:0]),
    .wdata_i   (wdata),
    .raddr_a_i (ia_ext[AW-1:0]),
    .raddr_b_i (ib_ext[AW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  logic rd_vld_q, a_ok_q, b_ok_q;
  logic d_vld_q;
  logic [MAG_W-1:0] mag_x_q, mag_y_q, mag_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      d_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= accept && op_i == OP_QUERY;
      d_vld_q  <= rd_vld_q;
    end
  end

  function automatic logic [MAG_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    logic signed [MAG_W-1:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  pos_t pa, pb;
  assign pa = a_ok_q ? rd_a : '0;
  assign pb = b_ok_q ? rd_b : '0;

  always_ff @(posedge clk_i) begin
    a_ok_q  <= ia_ok;
    b_ok_q  <= ib_ok;
    mag_x_q <= abs_diff(pa.x, pb.x);
    mag_y_q <= abs_diff(pa.y, pb.y);
    mag_z_q <= abs_diff(pa.z, pb.z);
  end

  logic            vx, vy, vz;
  logic [SQ_W-1:0] sqx, sqy, sqz;

  pbd_axis u_ax_x (.clk_i, .rst_ni, .valid_i(d_vld_q), .mag_i(mag_x_q),
                   .len_i(box_x_q), .valid_o(vx), .sq_o(sqx));
  pbd_axis u_ax_y (.clk_i, .rst_ni, .valid_i(d_vld_q), .mag_i(mag_y_q),
                   .len_i(box_y_q), .valid_o(vy), .sq_o(sqy));
  pbd_axis u_ax_z (.clk_i, .rst_ni, .valid_i(d_vld_q), .mag_i(mag_z_q),
                   .len_i(box_z_q), .valid_o(vz), .sq_o(sqz));

  logic            sum_vld_q;
  logic [SQ_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else begin
      sum_vld_q <= vx;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sqx + sqy + sqz;
  end

  logic              rt_vld;
  logic [SQ_W/2-1:0] root;
  logic              out_vld_q;
  logic [DIST_W-1:0] dist_q;

  pbd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_vld_q),
    .value_i (sum_q),
    .valid_o (rt_vld),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= rt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= root[DIST_W-1:0];
  end

  assign result_valid_o = out_vld_q;
  assign distance_o     = dist_q;

  ax_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vx == vy) && (vx == vz))
    else $error("axis pipelines out of step");

  out_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sum_vld_q) |=> ##31 rt_vld)
    else $error("square root latency broken");

  no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |=> d_vld_q)
    else $error("query lost after RAM read");

endmodule
